// ===== design/multi_waveform_generator_top_macros.svh =====
// Assertion helpers shared by the waveform generator RTL.
`ifndef MULTI_WAVEFORM_GENERATOR_TOP_MACROS_SVH
`define MULTI_WAVEFORM_GENERATOR_TOP_MACROS_SVH

// Property checked on every clock edge outside reset.
`define MWG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Antecedent this cycle, consequent on the next edge.
`define MWG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mwg_pkg.sv =====
`default_nettype none

package mwg_pkg;

  localparam int unsigned TIME_W      = 32;
  localparam int unsigned PHASE_W     = 32;
  localparam int unsigned SHAPE_W     = 16;
  localparam int unsigned SHAPE_FRAC  = 15;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned TBL_AW      = $clog2(TABLE_DEPTH);

  // APB register map
  localparam int unsigned APB_AW  = 4;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned REG_IW  = APB_AW - 2;
  localparam logic [REG_IW-1:0] REG_WAVE_MODE   = 2'd0;
  localparam logic [REG_IW-1:0] REG_PHASE_STEP  = 2'd1;
  localparam logic [REG_IW-1:0] REG_GAIN        = 2'd2;
  localparam logic [REG_IW-1:0] REG_LEVEL_SHIFT = 2'd3;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SAW      = 2'd3
  } wave_e;

  typedef struct packed {
    wave_e                   mode;
    logic [PHASE_W-1:0]      step;
    logic signed [CFG_W-1:0] gain;
    logic signed [CFG_W-1:0] level;
  } cfg_t;

  localparam logic signed [SHAPE_W-1:0] SHAPE_MAX = 16'sh7FFF;
  localparam logic signed [SHAPE_W-1:0] SHAPE_MIN = 16'sh8000;

  typedef struct packed {
    logic                      valid;
    logic signed [SHAPE_W-1:0] shape;
  } shape_beat_t;

  // Queues between and after the pipes
  localparam int unsigned MQ_DEPTH = 4;
  localparam int unsigned MQ_AW    = $clog2(MQ_DEPTH);
  localparam int unsigned MQ_CW    = $clog2(MQ_DEPTH + 1);
  typedef logic [MQ_CW-1:0] mq_cnt_t;
  typedef logic [MQ_CW:0]   mq_crd_t;
  localparam mq_cnt_t MQ_FULL  = mq_cnt_t'(MQ_DEPTH);
  localparam mq_crd_t MQ_LIMIT = mq_crd_t'(MQ_DEPTH);

  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);
  typedef logic [OQ_CW-1:0] oq_cnt_t;
  typedef logic [OQ_CW:0]   oq_crd_t;
  localparam oq_crd_t OQ_LIMIT = oq_crd_t'(OQ_DEPTH);

  // Scaling and saturation widths
  localparam int unsigned PROD_W   = CFG_W + SHAPE_W;
  localparam int unsigned SCALED_W = PROD_W - SHAPE_FRAC;
  localparam int unsigned SUM_W    = ((SCALED_W > CFG_W) ? SCALED_W : CFG_W) + 1;
  localparam int unsigned EXT_W    = (SAMPLE_BITS > SUM_W) ? SAMPLE_BITS : SUM_W;
  localparam logic signed [EXT_W-1:0] SAT_HI =
    EXT_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [EXT_W-1:0] SAT_LO = -SAT_HI - EXT_W'(1);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          clip;
  } res_t;

  // Sine table generation, evaluated at elaboration
  localparam logic [63:0] Q30_ONE     = 64'h4000_0000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SER_D1 = 64'd6;
  localparam logic [63:0] SER_D2 = 64'd20;
  localparam logic [63:0] SER_D3 = 64'd42;
  localparam logic [63:0] SER_D4 = 64'd72;
  localparam logic [63:0] SER_D5 = 64'd110;

  typedef logic signed [SHAPE_W-1:0] sine_tbl_t [TABLE_DEPTH];

  function automatic logic signed [SHAPE_W-1:0] sine_entry(input int unsigned n);
    logic [63:0] t;
    logic [63:0] r;
    logic [63:0] th;
    logic [63:0] t2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] val;
    logic [1:0]  quad;
    logic signed [SHAPE_W-1:0] mag;
    t    = 64'(n) << (PHASE_W - TBL_AW);
    quad = t[31:30];
    r    = t & (Q30_ONE - 64'd1);
    if (quad[0]) begin
      r = Q30_ONE - r;
    end
    th   = (r * HALF_PI_Q30) >> 30;
    t2   = (th * th) >> 30;
    term = th;
    sum  = th;
    // odd Taylor series up to x^11
    term = ((term * t2) >> 30) / SER_D1;
    sum  = sum - term;
    term = ((term * t2) >> 30) / SER_D2;
    sum  = sum + term;
    term = ((term * t2) >> 30) / SER_D3;
    sum  = sum - term;
    term = ((term * t2) >> 30) / SER_D4;
    sum  = sum + term;
    term = ((term * t2) >> 30) / SER_D5;
    sum  = sum - term;
    val  = (sum * 64'd32767 + 64'd536870912) >> 30;
    if (val > 64'd32767) begin
      val = 64'd32767;
    end
    mag = $signed(val[SHAPE_W-1:0]);
    return quad[1] ? -mag : mag;
  endfunction

  function automatic sine_tbl_t sine_table();
    sine_tbl_t tbl;
    for (int unsigned n = 0; n < TABLE_DEPTH; n++) begin
      tbl[n] = sine_entry(n);
    end
    return tbl;
  endfunction

endpackage

`default_nettype wire

// ===== design/mwg_cfg.sv =====
`default_nettype none

module mwg_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mwg_pkg::APB_AW-1:0]  paddr,
  input  wire logic [mwg_pkg::APB_DW-1:0]  pwdata,
  output logic      [mwg_pkg::APB_DW-1:0]  prdata,
  output logic                             pready,
  output mwg_pkg::cfg_t                    cfg_o
);

  mwg_pkg::cfg_t                   cfg_q;
  logic                            wr_en;
  logic [mwg_pkg::REG_IW-1:0]      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[mwg_pkg::APB_AW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode  <= mwg_pkg::WAVE_SINE;
      cfg_q.step  <= '0;
      cfg_q.gain  <= '0;
      cfg_q.level <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        mwg_pkg::REG_WAVE_MODE:   cfg_q.mode  <= mwg_pkg::wave_e'(pwdata[1:0]);
        mwg_pkg::REG_PHASE_STEP:  cfg_q.step  <= pwdata[mwg_pkg::PHASE_W-1:0];
        mwg_pkg::REG_GAIN:        cfg_q.gain  <= $signed(pwdata[mwg_pkg::CFG_W-1:0]);
        mwg_pkg::REG_LEVEL_SHIFT: cfg_q.level <= $signed(pwdata[mwg_pkg::CFG_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mwg_pkg::REG_WAVE_MODE:   prdata = mwg_pkg::APB_DW'(cfg_q.mode);
      mwg_pkg::REG_PHASE_STEP:  prdata = mwg_pkg::APB_DW'(cfg_q.step);
      mwg_pkg::REG_GAIN:        prdata = mwg_pkg::APB_DW'($unsigned(cfg_q.gain));
      mwg_pkg::REG_LEVEL_SHIFT: prdata = mwg_pkg::APB_DW'($unsigned(cfg_q.level));
      default:                  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== design/mwg_front.sv =====
`default_nettype none

module mwg_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mwg_pkg::cfg_t                 cfg_i,
  input  wire logic                          push_i,
  input  wire logic [mwg_pkg::TIME_W-1:0]    tick_time_i,
  input  wire mwg_pkg::mq_cnt_t              mq_count_i,
  output logic                               full_o,
  output mwg_pkg::shape_beat_t               mq_wr_o
);

  localparam mwg_pkg::sine_tbl_t SINE_ROM = mwg_pkg::sine_table();

  logic                               in_fire;
  mwg_pkg::mq_crd_t                   credit;
  logic                               v1_q;
  logic                               v2_q;
  logic [mwg_pkg::PHASE_W-1:0]        phase_d;
  logic [mwg_pkg::PHASE_W-1:0]        phase_q;
  logic signed [mwg_pkg::SHAPE_W-1:0] rom_q;
  logic signed [mwg_pkg::SHAPE_W-1:0] wave_d;
  logic signed [mwg_pkg::SHAPE_W-1:0] wave_q;
  logic [mwg_pkg::PHASE_W-1:0]        tri_p;
  logic signed [mwg_pkg::SHAPE_W+1:0] tri_s;

  // reserve a queue slot for every beat still in the pipe
  assign credit  = mwg_pkg::mq_crd_t'(mq_count_i) + mwg_pkg::mq_crd_t'(v1_q)
                 + mwg_pkg::mq_crd_t'(v2_q);
  assign full_o  = (credit >= mwg_pkg::MQ_LIMIT);
  assign in_fire = push_i & ~full_o;

  // only the low half of the product is kept
  assign phase_d = cfg_i.step * tick_time_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= in_fire;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q <= phase_d;
    rom_q   <= SINE_ROM[phase_q[mwg_pkg::PHASE_W-1 -: mwg_pkg::TBL_AW]];
    wave_q  <= wave_d;
  end

  always_comb begin
    tri_p = phase_q + 32'h4000_0000;
    if (tri_p <= 32'h8000_0000) begin
      tri_s = $signed({1'b0, tri_p[31:15]}) - 18'sd32768;
    end else begin
      tri_s = 18'sd32768 - $signed({2'b00, tri_p[30:15]});
    end
  end

  always_comb begin
    unique case (cfg_i.mode)
      mwg_pkg::WAVE_SINE: begin
        wave_d = '0;
      end
      mwg_pkg::WAVE_SQUARE: begin
        wave_d = (phase_q <= 32'h8000_0000) ? mwg_pkg::SHAPE_MAX : mwg_pkg::SHAPE_MIN;
      end
      mwg_pkg::WAVE_TRIANGLE: begin
        wave_d = (tri_s > 18'sd32767) ? mwg_pkg::SHAPE_MAX
                                      : tri_s[mwg_pkg::SHAPE_W-1:0];
      end
      mwg_pkg::WAVE_SAW: begin
        // half-cycle shift and offset cancel: the top phase bits are the shape
        wave_d = $signed(phase_q[mwg_pkg::PHASE_W-1 -: mwg_pkg::SHAPE_W]);
      end
      default: begin
        wave_d = '0;
      end
    endcase
  end

  assign mq_wr_o.valid = v2_q;
  assign mq_wr_o.shape = (cfg_i.mode == mwg_pkg::WAVE_SINE) ? rom_q : wave_q;

endmodule

`default_nettype wire

// ===== design/mwg_queue.sv =====
`default_nettype none

`include "multi_waveform_generator_top_macros.svh"

module mwg_queue (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mwg_pkg::shape_beat_t          wr_i,
  input  wire logic                          rd_i,
  output mwg_pkg::mq_cnt_t                   count_o,
  output logic                               empty_o,
  output logic signed [mwg_pkg::SHAPE_W-1:0] rd_data_o
);

  logic signed [mwg_pkg::SHAPE_W-1:0] mem_q [mwg_pkg::MQ_DEPTH];
  logic [mwg_pkg::MQ_AW-1:0]          wr_ptr_q;
  logic [mwg_pkg::MQ_AW-1:0]          rd_ptr_q;
  mwg_pkg::mq_cnt_t                   count_d;
  mwg_pkg::mq_cnt_t                   count_q;

  assign count_d = count_q + mwg_pkg::mq_cnt_t'(wr_i.valid) - mwg_pkg::mq_cnt_t'(rd_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i.valid) begin
        wr_ptr_q <= wr_ptr_q + mwg_pkg::MQ_AW'(1);
      end
      if (rd_i) begin
        rd_ptr_q <= rd_ptr_q + mwg_pkg::MQ_AW'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.valid) begin
      mem_q[wr_ptr_q] <= wr_i.shape;
    end
  end

  assign rd_data_o = mem_q[rd_ptr_q];
  assign empty_o   = (count_q == '0);
  assign count_o   = count_q;

  `MWG_ASSERT(a_mq_no_overflow, wr_i.valid |-> (count_q < mwg_pkg::MQ_FULL), "mid queue written while full")
  `MWG_ASSERT(a_mq_no_underflow, rd_i |-> !empty_o, "mid queue read while empty")
  `MWG_ASSERT_NEXT(a_mq_count_drop, rd_i && !wr_i.valid, count_q == $past(count_q) - mwg_pkg::mq_cnt_t'(1), "mid queue count did not drop on read")

endmodule

`default_nettype wire

// ===== design/mwg_back.sv =====
`default_nettype none

`include "multi_waveform_generator_top_macros.svh"

module mwg_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire mwg_pkg::cfg_t                     cfg_i,
  input  wire logic                              mq_empty_i,
  input  wire logic signed [mwg_pkg::SHAPE_W-1:0] mq_data_i,
  output logic                                   mq_rd_o,
  input  wire logic                              pop_i,
  output logic                                   empty_o,
  output logic signed [mwg_pkg::SAMPLE_BITS-1:0] sample_value_o,
  output logic                                   clipped_o
);

  logic                                 take;
  mwg_pkg::oq_crd_t                     credit;
  logic                                 bv1_q;
  logic                                 bv2_q;
  logic signed [mwg_pkg::PROD_W-1:0]    prod_d;
  logic signed [mwg_pkg::PROD_W-1:0]    prod_q;
  logic signed [mwg_pkg::SCALED_W-1:0]  scaled;
  logic signed [mwg_pkg::EXT_W-1:0]     sum_ext;
  mwg_pkg::res_t                        res_d;
  mwg_pkg::res_t                        res_q;
  mwg_pkg::res_t                        oq_mem_q [mwg_pkg::OQ_DEPTH];
  logic [mwg_pkg::OQ_AW-1:0]            oq_wr_ptr_q;
  logic [mwg_pkg::OQ_AW-1:0]            oq_rd_ptr_q;
  mwg_pkg::oq_cnt_t                     oq_count_d;
  mwg_pkg::oq_cnt_t                     oq_count_q;
  logic                                 out_fire;

  assign credit  = mwg_pkg::oq_crd_t'(oq_count_q) + mwg_pkg::oq_crd_t'(bv1_q)
                 + mwg_pkg::oq_crd_t'(bv2_q);
  assign take    = ~mq_empty_i & (credit < mwg_pkg::OQ_LIMIT);
  assign mq_rd_o = take;

  assign prod_d = cfg_i.gain * mq_data_i;

  // arithmetic shift floors toward minus infinity
  assign scaled  = prod_q[mwg_pkg::PROD_W-1:mwg_pkg::SHAPE_FRAC];
  assign sum_ext = mwg_pkg::EXT_W'(scaled) + mwg_pkg::EXT_W'(cfg_i.level);

  always_comb begin
    if (sum_ext > mwg_pkg::SAT_HI) begin
      res_d.sample = mwg_pkg::SAT_HI[mwg_pkg::SAMPLE_BITS-1:0];
      res_d.clip   = 1'b1;
    end else if (sum_ext < mwg_pkg::SAT_LO) begin
      res_d.sample = mwg_pkg::SAT_LO[mwg_pkg::SAMPLE_BITS-1:0];
      res_d.clip   = 1'b1;
    end else begin
      res_d.sample = sum_ext[mwg_pkg::SAMPLE_BITS-1:0];
      res_d.clip   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv1_q <= 1'b0;
      bv2_q <= 1'b0;
    end else begin
      bv1_q <= take;
      bv2_q <= bv1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    res_q  <= res_d;
  end

  // output queue
  assign out_fire   = pop_i & ~empty_o;
  assign oq_count_d = oq_count_q + mwg_pkg::oq_cnt_t'(bv2_q) - mwg_pkg::oq_cnt_t'(out_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_ptr_q <= '0;
      oq_rd_ptr_q <= '0;
      oq_count_q  <= '0;
    end else begin
      if (bv2_q) begin
        oq_wr_ptr_q <= oq_wr_ptr_q + mwg_pkg::OQ_AW'(1);
      end
      if (out_fire) begin
        oq_rd_ptr_q <= oq_rd_ptr_q + mwg_pkg::OQ_AW'(1);
      end
      oq_count_q <= oq_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bv2_q) begin
      oq_mem_q[oq_wr_ptr_q] <= res_q;
    end
  end

  assign empty_o        = (oq_count_q == '0);
  assign sample_value_o = oq_mem_q[oq_rd_ptr_q].sample;
  assign clipped_o      = oq_mem_q[oq_rd_ptr_q].clip;

  `MWG_ASSERT(a_oq_credit, credit <= mwg_pkg::OQ_LIMIT, "output queue overcommitted")
  `MWG_ASSERT(a_clip_at_rail, (bv2_q && res_q.clip) |-> ((res_q.sample == mwg_pkg::SAT_HI[mwg_pkg::SAMPLE_BITS-1:0]) || (res_q.sample == mwg_pkg::SAT_LO[mwg_pkg::SAMPLE_BITS-1:0])), "clip flag without rail value")

endmodule

`default_nettype wire

// ===== design/multi_waveform_generator_top.sv =====
`default_nettype none

// Fixed-point DDS waveform generator. Each beat pushed in carries a time in
// sample ticks; the block returns one sample per beat, in order: the phase is
// the low 32 bits of phase_step * tick_time, shaped as sine (1024-entry ROM on
// the top phase bits), square, triangle or sawtooth in Q1.15, scaled by gain
// (floor of the >>15), offset by level_shift and saturated, with clipped set on
// saturation. Registers sit at byte addresses 0 (wave_mode), 4 (phase_step),
// 8 (gain) and 12 (level_shift); write them only while no beat is in flight.
// Throughput is one beat per clock while full is low; after its push is accepted,
// a result passes through two front stages (32x32 phase multiply, sine ROM
// read / shape logic), the mid queue, two back stages (16x16 gain multiply,
// offset and saturation), then the output queue. full is asserted from a credit
// count over the 4-entry mid queue and its in-flight beats, so an item is never
// dropped when the output side stalls.
module multi_waveform_generator_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mwg_pkg::APB_AW-1:0]         paddr,
  input  wire logic [mwg_pkg::APB_DW-1:0]         pwdata,
  output logic      [mwg_pkg::APB_DW-1:0]         prdata,
  output logic                                    pready,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic [mwg_pkg::TIME_W-1:0]         tick_time_i,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic signed [mwg_pkg::SAMPLE_BITS-1:0]  sample_value_o,
  output logic                                    clipped_o
);

  mwg_pkg::cfg_t                      cfg;
  mwg_pkg::shape_beat_t               mq_wr;
  mwg_pkg::mq_cnt_t                   mq_count;
  logic                               mq_empty;
  logic                               mq_rd;
  logic signed [mwg_pkg::SHAPE_W-1:0] mq_data;

  mwg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mwg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .push_i      (push),
    .tick_time_i (tick_time_i),
    .mq_count_i  (mq_count),
    .full_o      (full),
    .mq_wr_o     (mq_wr)
  );

  mwg_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (mq_wr),
    .rd_i      (mq_rd),
    .count_o   (mq_count),
    .empty_o   (mq_empty),
    .rd_data_o (mq_data)
  );

  mwg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .mq_empty_i     (mq_empty),
    .mq_data_i      (mq_data),
    .mq_rd_o        (mq_rd),
    .pop_i          (pop),
    .empty_o        (empty),
    .sample_value_o (sample_value_o),
    .clipped_o      (clipped_o)
  );

endmodule

`default_nettype wire
